### rtl/dmc_pkg.sv
`default_nettype none

package dmc_pkg;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_SLASH,
        M_BLOCK,
        M_BSTAR,
        M_LINE,
        M_STRING,
        M_CHAR,
        M_CTAIL
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_WRONG    = 3'd2,
        ST_COMMENT  = 3'd3,
        ST_STRING   = 3'd4,
        ST_BADCHAR  = 3'd5,
        ST_UNCLOSED = 3'd6,
        ST_OVERFLOW = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        K_ROUND,
        K_SQUARE,
        K_CURLY
    } t_kind;

    // stack operation for one transfer; clear wins over push and pop
    typedef struct packed {
        logic  clear;
        logic  push;
        logic  pop;
        t_kind kind;
    } t_stack_cmd;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

endpackage

`default_nettype wire

### rtl/dmc_ram.sv
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/dmc_stack.sv
`default_nettype none

module dmc_stack
    import dmc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    localparam int TOP_W = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_stack_cmd       i_cmd,
    output logic      [TOP_W-1:0] o_top,
    output t_kind                 o_tos
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // top of stack lives in r_tos; the RAM holds every entry below it
    logic [TOP_W-1:0]  r_top;
    logic [TOP_W-1:0]  n_top;
    t_kind             r_tos;
    t_kind             n_tos;
    logic              r_byp;
    t_kind             r_byp_kind;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [TOP_W-1:0]  w_top_m1;
    logic [TOP_W-1:0]  w_ntop_m2;
    logic [1:0]        w_rd_data;
    t_kind             w_below;

    assign w_top_m1  = r_top - TOP_W'(1);
    assign w_ntop_m2 = n_top - TOP_W'(2);
    assign w_wr_en   = i_cmd.push && !i_cmd.clear && (r_top != '0);
    assign w_wr_addr = w_top_m1[ADDR_W-1:0];
    // prefetch the entry that a pop after this transfer exposes
    assign w_rd_addr = w_ntop_m2[ADDR_W-1:0];
    assign w_below   = r_byp ? r_byp_kind : t_kind'(w_rd_data);

    always_comb begin
        n_top = r_top;
        n_tos = r_tos;
        if (i_cmd.clear) begin
            n_top = '0;
        end else if (i_cmd.push) begin
            n_top = r_top + TOP_W'(1);
            n_tos = i_cmd.kind;
        end else if (i_cmd.pop) begin
            n_top = w_top_m1;
            n_tos = w_below;
        end
    end

    dmc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_tos),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_byp <= 1'b0;
        end else begin
            r_top <= n_top;
            // read and write on the same entry: take the new data
            r_byp <= w_wr_en && (w_wr_addr == w_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos      <= n_tos;
        r_byp_kind <= r_tos;
    end

    assign o_top = r_top;
    assign o_tos = r_tos;

endmodule

`default_nettype wire

### rtl/delimiter_match_checker_unit.sv
// Bracket nesting checker for a stream of source text bytes.
// Input channel: i_in_valid / o_in_ready carry one byte (i_char_in) and a
// last-byte mark (i_last_byte). Output channel: o_out_valid / i_out_ready
// carry one result: o_out_status and o_out_line_number.
// A text yields exactly one result: at the first error (bracket, comment,
// string or literal fault, or stack overflow), or at its last byte.
// After an error the remaining bytes are consumed silently until the last
// byte. The last byte always resets the lexer, line count and stack.
// Throughput: one byte per cycle while o_in_ready is high. Each byte is
// lexed and the bracket stack is updated in the cycle of its transfer; the
// top of stack is held in a register and the entry below it is prefetched
// from the stack RAM, so consecutive pushes and pops run back to back.
// Results: each result is registered in the output register, or in the
// skid entry while the output register is held.
// Stall: an output register plus one skid entry hold results; o_in_ready
// drops only while the skid entry is occupied.
// Reset: synchronous, active low; clears control state. The stack RAM is
// not cleared; entries are always written before they are read.
`default_nettype none

module delimiter_match_checker_unit
    import dmc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_char_in,
    input  wire logic                 i_last_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [2:0]           o_out_status,
    output logic      [LINE_BITS-1:0] o_out_line_number
);

    localparam int TOP_W = $clog2(STACK_DEPTH + 1);
    localparam logic [TOP_W-1:0]     TOP_FULL = TOP_W'(STACK_DEPTH);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    t_mode                r_mode;
    t_mode                n_mode;
    logic [1:0]           r_lit_len;
    logic [1:0]           n_lit_len;
    logic [LINE_BITS-1:0] r_line;
    logic [LINE_BITS-1:0] r_quote_line;
    logic                 r_err;

    logic                 w_fire;
    logic                 w_plain;
    logic                 w_push;
    logic                 w_pop;
    t_kind                w_kind;
    t_status              w_status;
    logic                 w_err_at_quote;
    logic                 w_set_quote;
    logic [LINE_BITS-1:0] w_line;
    logic [LINE_BITS-1:0] w_quote;
    logic                 w_nonempty;
    t_status              w_end_status;
    logic [LINE_BITS-1:0] w_end_line;
    logic                 w_res_valid;
    t_status              w_res_status;
    logic [LINE_BITS-1:0] w_res_line;
    t_stack_cmd           w_cmd;
    logic [TOP_W-1:0]     w_top;
    t_kind                w_tos;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [LINE_BITS-1:0] r_out_line;
    logic                 r_skid_valid;
    t_status              r_skid_status;
    logic [LINE_BITS-1:0] r_skid_line;

    function automatic t_mode f_plain_mode(input logic [7:0] c);
        t_mode m;
        m = M_NORMAL;
        if (c == CH_SLASH) begin
            m = M_SLASH;
        end else if (c == CH_DQUOTE) begin
            m = M_STRING;
        end else if (c == CH_SQUOTE) begin
            m = M_CHAR;
        end
        return m;
    endfunction

    function automatic t_kind f_kind(input logic [7:0] c);
        t_kind k;
        k = K_CURLY;
        if (c == CH_LPAREN || c == CH_RPAREN) begin
            k = K_ROUND;
        end else if (c == CH_LBRACK || c == CH_RBRACK) begin
            k = K_SQUARE;
        end
        return k;
    endfunction

    assign o_in_ready = !r_skid_valid;
    assign w_fire     = i_in_valid && o_in_ready;

    // line count advances before the byte is lexed
    assign w_line = (i_char_in == CH_NL && r_line != LINE_MAX) ? r_line + LINE_ONE : r_line;

    // lexer next state
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            M_NORMAL: begin
                n_mode = f_plain_mode(i_char_in);
            end
            M_SLASH: begin
                if (i_char_in == CH_STAR) begin
                    n_mode = M_BLOCK;
                end else if (i_char_in == CH_SLASH) begin
                    n_mode = M_LINE;
                end else begin
                    n_mode = f_plain_mode(i_char_in);
                end
            end
            M_BLOCK: begin
                if (i_char_in == CH_STAR) begin
                    n_mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (i_char_in == CH_SLASH) begin
                    n_mode = M_NORMAL;
                end else if (i_char_in != CH_STAR) begin
                    n_mode = M_BLOCK;
                end
            end
            M_LINE: begin
                if (i_char_in == CH_NL) begin
                    n_mode = M_NORMAL;
                end
            end
            M_STRING: begin
                if (i_char_in == CH_DQUOTE) begin
                    n_mode = M_NORMAL;
                end
            end
            M_CHAR: begin
                if (r_lit_len != 2'd0 && i_char_in == CH_SQUOTE) begin
                    n_mode = (r_lit_len == 2'd1) ? M_CTAIL : M_NORMAL;
                end
            end
            M_CTAIL: begin
                n_mode = (i_char_in == CH_SQUOTE) ? M_NORMAL : f_plain_mode(i_char_in);
            end
            default: begin
                n_mode = M_NORMAL;
            end
        endcase
    end

    // lexer outputs: stack operation, status, literal length
    always_comb begin
        w_plain = (r_mode == M_NORMAL)
               || (r_mode == M_SLASH && i_char_in != CH_STAR && i_char_in != CH_SLASH)
               || (r_mode == M_CTAIL && i_char_in != CH_SQUOTE);
        w_push         = 1'b0;
        w_pop          = 1'b0;
        w_kind         = f_kind(i_char_in);
        w_status       = ST_OK;
        w_err_at_quote = 1'b0;
        w_set_quote    = 1'b0;
        n_lit_len      = r_lit_len;

        if (r_mode == M_CHAR) begin
            if (r_lit_len == 2'd0) begin
                n_lit_len = 2'd1;
            end else if (i_char_in != CH_SQUOTE) begin
                if (r_lit_len == 2'd3) begin
                    w_status       = ST_BADCHAR;
                    w_err_at_quote = 1'b1;
                end else begin
                    n_lit_len = r_lit_len + 2'd1;
                end
            end
        end

        if (w_plain) begin
            unique case (i_char_in) inside
                CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
                    if (w_top == TOP_FULL) begin
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_push = 1'b1;
                    end
                end
                CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
                    if (w_top == '0) begin
                        w_status = ST_EMPTY;
                    end else if (w_tos != w_kind) begin
                        w_status = ST_WRONG;
                    end else begin
                        w_pop = 1'b1;
                    end
                end
                CH_DQUOTE: begin
                    w_set_quote = 1'b1;
                end
                CH_SQUOTE: begin
                    w_set_quote = 1'b1;
                    n_lit_len   = 2'd0;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_quote = w_set_quote ? w_line : r_quote_line;

    always_comb begin
        if (w_push) begin
            w_nonempty = 1'b1;
        end else if (w_pop) begin
            w_nonempty = (w_top != TOP_W'(1));
        end else begin
            w_nonempty = (w_top != '0);
        end
    end

    // end-of-text check on the state left by the last byte
    always_comb begin
        w_end_line = w_line;
        if (n_mode == M_BLOCK || n_mode == M_BSTAR) begin
            w_end_status = ST_COMMENT;
        end else if (n_mode == M_STRING) begin
            w_end_status = ST_STRING;
            w_end_line   = w_quote;
        end else if (n_mode == M_CHAR) begin
            w_end_status = ST_BADCHAR;
            w_end_line   = w_quote;
        end else if (w_nonempty) begin
            w_end_status = ST_UNCLOSED;
        end else begin
            w_end_status = ST_OK;
        end
    end

    assign w_res_valid  = w_fire && !r_err && (w_status != ST_OK || i_last_byte);
    assign w_res_status = (w_status != ST_OK) ? w_status : w_end_status;
    assign w_res_line   = (w_status != ST_OK) ? (w_err_at_quote ? r_quote_line : w_line)
                                              : w_end_line;

    assign w_cmd.clear = w_fire && i_last_byte;
    assign w_cmd.push  = w_fire && !r_err && w_push;
    assign w_cmd.pop   = w_fire && !r_err && w_pop;
    assign w_cmd.kind  = w_kind;

    dmc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_top   (w_top),
        .o_tos   (w_tos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_NORMAL;
            r_lit_len    <= 2'd0;
            r_line       <= LINE_ONE;
            r_quote_line <= '0;
            r_err        <= 1'b0;
        end else if (w_fire) begin
            if (i_last_byte) begin
                r_mode       <= M_NORMAL;
                r_lit_len    <= 2'd0;
                r_line       <= LINE_ONE;
                r_quote_line <= '0;
                r_err        <= 1'b0;
            end else if (!r_err) begin
                if (w_status != ST_OK) begin
                    r_err <= 1'b1;
                end else begin
                    r_mode       <= n_mode;
                    r_lit_len    <= n_lit_len;
                    r_line       <= w_line;
                    r_quote_line <= w_quote;
                end
            end
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= w_res_valid;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_status <= r_skid_status;
                r_out_line   <= r_skid_line;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_status <= w_res_status;
            r_out_line   <= w_res_line;
        end else begin
            r_skid_status <= w_res_status;
            r_skid_line   <= w_res_line;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_line_number = r_out_line;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_top <= TOP_FULL)
        else $error("stack pointer beyond depth");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_last_byte) |=> (w_top == '0 && !r_err && r_mode == M_NORMAL
                                     && r_line == LINE_ONE))
        else $error("last byte did not return block to idle state");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_err) |-> !w_res_valid)
        else $error("result produced after an error was latched");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter wrapped to zero");
`endif

endmodule

`default_nettype wire

### tb/bracket_status_monitor.sv
`timescale 1ns / 1ps

module bracket_status_monitor
    import dmc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [7:0]           i_char_in,
    input  wire logic                 i_last_byte,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [2:0]           i_out_status,
    input  wire logic [LINE_BITS-1:0] i_out_line_number,
    output int                        o_awaited,
    output int                        o_checked,
    output int                        o_faults
);

    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

    typedef struct {
        t_status              status;
        logic [LINE_BITS-1:0] line;
    } t_text_result;

    t_text_result awaited_results[$];

    // lexer and bracket state of the text in progress
    t_kind                kind_stack [STACK_DEPTH];
    int unsigned          stack_fill = 0;
    logic [LINE_BITS-1:0] line_cnt   = 1;
    t_mode                mode       = M_NORMAL;
    int                   lit_len    = 0;
    logic [LINE_BITS-1:0] quote_line = '0;
    logic [LINE_BITS-1:0] fault_line = '0;
    bit                   latched    = 1'b0;

    int checked = 0;
    int faults  = 0;

    function automatic void clear_text_state();
        stack_fill = 0;
        line_cnt   = 1;
        mode       = M_NORMAL;
        lit_len    = 0;
        quote_line = '0;
        latched    = 1'b0;
    endfunction

    function automatic t_status plain_char(input logic [7:0] c);
        t_kind k;
        k = K_ROUND;
        if (c == CH_LBRACK || c == CH_RBRACK) k = K_SQUARE;
        else if (c == CH_LBRACE || c == CH_RBRACE) k = K_CURLY;
        case (c)
            CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
                if (stack_fill >= STACK_DEPTH) begin
                    fault_line = line_cnt;
                    return ST_OVERFLOW;
                end
                kind_stack[stack_fill] = k;
                stack_fill++;
            end
            CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
                fault_line = line_cnt;
                if (stack_fill == 0) return ST_EMPTY;
                if (kind_stack[stack_fill-1] != k) return ST_WRONG;
                stack_fill--;
            end
            CH_SLASH: mode = M_SLASH;
            CH_DQUOTE: begin
                mode       = M_STRING;
                quote_line = line_cnt;
            end
            CH_SQUOTE: begin
                mode       = M_CHAR;
                lit_len    = 0;
                quote_line = line_cnt;
            end
            default: ;
        endcase
        return ST_OK;
    endfunction

    function automatic t_status lex_char(input logic [7:0] c);
        case (mode)
            M_SLASH: begin
                if (c == CH_STAR) begin
                    mode = M_BLOCK;
                    return ST_OK;
                end
                if (c == CH_SLASH) begin
                    mode = M_LINE;
                    return ST_OK;
                end
                mode = M_NORMAL;
                return plain_char(c);
            end
            M_BLOCK: begin
                if (c == CH_STAR) mode = M_BSTAR;
                return ST_OK;
            end
            M_BSTAR: begin
                if (c == CH_SLASH) mode = M_NORMAL;
                else if (c != CH_STAR) mode = M_BLOCK;
                return ST_OK;
            end
            M_LINE: begin
                if (c == CH_NL) mode = M_NORMAL;
                return ST_OK;
            end
            M_STRING: begin
                if (c == CH_DQUOTE) mode = M_NORMAL;
                return ST_OK;
            end
            M_CHAR: begin
                if (lit_len == 0) begin
                    lit_len = 1;
                    return ST_OK;
                end
                if (c == CH_SQUOTE) begin
                    // a one-character literal may swallow one more quote
                    if (lit_len == 1) mode = M_CTAIL;
                    else mode = M_NORMAL;
                    return ST_OK;
                end
                if (lit_len >= 3) begin
                    fault_line = quote_line;
                    return ST_BADCHAR;
                end
                lit_len++;
                return ST_OK;
            end
            M_CTAIL: begin
                mode = M_NORMAL;
                if (c == CH_SQUOTE) return ST_OK;
                return plain_char(c);
            end
            default: begin
                mode = M_NORMAL;
                return plain_char(c);
            end
        endcase
    endfunction

    function automatic t_status end_status();
        if (mode == M_BLOCK || mode == M_BSTAR) begin
            fault_line = line_cnt;
            return ST_COMMENT;
        end
        if (mode == M_STRING) begin
            fault_line = quote_line;
            return ST_STRING;
        end
        if (mode == M_CHAR) begin
            fault_line = quote_line;
            return ST_BADCHAR;
        end
        fault_line = line_cnt;
        if (stack_fill != 0) return ST_UNCLOSED;
        return ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_status      st;
        t_text_result want;
        if (!i_rst_n) begin
            clear_text_state();
            awaited_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (!latched) begin
                    if (i_char_in == CH_NL && line_cnt != LINE_TOP) line_cnt++;
                    st = lex_char(i_char_in);
                    if (st != ST_OK) begin
                        latched = 1'b1;
                        awaited_results.push_back(t_text_result'{st, fault_line});
                    end else if (i_last_byte) begin
                        st = end_status();
                        awaited_results.push_back(t_text_result'{st, fault_line});
                    end
                end
                if (i_last_byte) clear_text_state();
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d, line_number %0d",
                           i_out_status, i_out_line_number);
                    faults++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_status);
                        faults++;
                    end
                    if (i_out_line_number !== want.line) begin
                        $error("line_number: expected %0d, got %0d",
                               want.line, i_out_line_number);
                        faults++;
                    end
                    checked++;
                end
            end
        end
        o_awaited <= awaited_results.size();
        o_checked <= checked;
        o_faults  <= faults;
    end

endmodule

### tb/delimiter_match_checker_unit_test.sv
`timescale 1ns / 1ps

module delimiter_match_checker_unit_test;
    import dmc_pkg::*;

    localparam int DEPTH = 64;
    localparam int LBITS = 16;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic [7:0]       i_char_in   = '0;
    logic             i_last_byte = 1'b0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [2:0]       o_out_status;
    logic [LBITS-1:0] o_out_line_number;

    int tx_idle_pct = 28;
    int rx_idle_pct = 49;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int n_bytes     = 0;
    int n_texts     = 0;
    int n_awaited;
    int n_checked;
    int n_faults;

    logic [7:0] text_bytes[$];

    delimiter_match_checker_unit #(
        .STACK_DEPTH(DEPTH),
        .LINE_BITS  (LBITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_char_in        (i_char_in),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_status     (o_out_status),
        .o_out_line_number(o_out_line_number)
    );

    bracket_status_monitor #(
        .STACK_DEPTH(DEPTH),
        .LINE_BITS  (LBITS)
    ) monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_char_in        (i_char_in),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_status     (o_out_status),
        .i_out_line_number(o_out_line_number),
        .o_awaited        (n_awaited),
        .o_checked        (n_checked),
        .o_faults         (n_faults)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result sink: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_reqs;
            hold_left   <= 200;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] open_char(input t_kind k);
        case (k)
            K_ROUND:  return CH_LPAREN;
            K_SQUARE: return CH_LBRACK;
            default:  return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input t_kind k);
        case (k)
            K_ROUND:  return CH_RPAREN;
            K_SQUARE: return CH_RBRACK;
            default:  return CH_RBRACE;
        endcase
    endfunction

    // byte for comment, string or literal bodies; never returns 'banned'
    function automatic logic [7:0] body_char(input logic [7:0] banned);
        logic [7:0] c;
        do begin
            case ($urandom_range(0, 9))
                0:       c = CH_NL;
                1:       c = CH_STAR;
                2:       c = CH_LPAREN;
                3:       c = CH_RBRACE;
                4:       c = CH_DQUOTE;
                5:       c = CH_SQUOTE;
                6:       c = CH_SLASH;
                default: c = letter();
            endcase
        end while (c == banned);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_in   <= c;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_bytes++;
    endtask

    task automatic send_text();
        foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
        n_texts++;
    endtask

    task automatic send_str(input string s);
        text_bytes.delete();
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
        send_text();
    endtask

    // nested brackets, comments, strings, literals; damaged unless clean
    task automatic compose_text(input bit clean);
        t_kind open_kinds[$];
        t_kind k;
        int    n;
        int    p;
        text_bytes.delete();
        repeat ($urandom_range(3, 24)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if (open_kinds.size() < 20) begin
                        k = t_kind'($urandom_range(0, 2));
                        open_kinds.push_back(k);
                        text_bytes.push_back(open_char(k));
                    end else begin
                        text_bytes.push_back(letter());
                    end
                end
                2, 3: begin
                    if (open_kinds.size() != 0)
                        text_bytes.push_back(close_char(open_kinds.pop_back()));
                    else
                        text_bytes.push_back(letter());
                end
                4: text_bytes.push_back(CH_NL);
                5: begin
                    text_bytes.push_back(CH_SLASH);
                    text_bytes.push_back(CH_STAR);
                    repeat ($urandom_range(0, 6)) text_bytes.push_back(body_char(CH_SLASH));
                    text_bytes.push_back(CH_STAR);
                    text_bytes.push_back(CH_SLASH);
                end
                6: begin
                    text_bytes.push_back(CH_SLASH);
                    text_bytes.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 6)) text_bytes.push_back(body_char(CH_NL));
                    text_bytes.push_back(CH_NL);
                end
                7: begin
                    text_bytes.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 6)) text_bytes.push_back(body_char(CH_DQUOTE));
                    text_bytes.push_back(CH_DQUOTE);
                end
                8: begin
                    n = $urandom_range(1, 3);
                    text_bytes.push_back(CH_SQUOTE);
                    text_bytes.push_back(body_char(8'h00));
                    repeat (n - 1) text_bytes.push_back(body_char(CH_SQUOTE));
                    text_bytes.push_back(CH_SQUOTE);
                    // keep the next literal's quote from being eaten as a tail
                    if (n == 1)
                        text_bytes.push_back($urandom_range(0, 1) ? CH_SQUOTE : letter());
                end
                default: text_bytes.push_back(letter());
            endcase
        end
        while (open_kinds.size() != 0) text_bytes.push_back(close_char(open_kinds.pop_back()));
        if (!clean) begin
            p = $urandom_range(0, text_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: text_bytes[p] = body_char(CH_NL);
                1: while (text_bytes.size() > p + 1) void'(text_bytes.pop_back());
                default: text_bytes.insert(p, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_random(input int min_bytes, input int min_texts);
        int b0;
        int t0;
        int roll;
        b0 = n_bytes;
        t0 = n_texts;
        while (n_bytes - b0 < min_bytes || n_texts - t0 < min_texts) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                text_bytes.delete();
                repeat ($urandom_range(1, 16)) text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                compose_text(roll > 2);
            end
            send_text();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_str("()");
        send_str(")");
        send_str("(]");
        send_str("/*");
        send_str("\"a");
        send_str("'abcd");
        send_str("'a");
        send_str("'a''");
        send_str("/(");
        send_str("/***/");
        send_str("//");
        send_str("{\n");
        // error, then ignored bytes up to the last one
        text_bytes = '{CH_RPAREN, 8'hFF, 8'h00};
        send_text();

        run_random(40, 2);
        tx_idle_pct = 49;
        rx_idle_pct = 28;
        run_random(40, 2);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(40, 2);

        // one opening bracket past a full stack
        text_bytes.delete();
        repeat (DEPTH + 1) text_bytes.push_back(CH_LPAREN);
        text_bytes.push_back(letter());
        send_text();
        // fill the stack exactly, then drain it
        text_bytes.delete();
        repeat (DEPTH) text_bytes.push_back(CH_LBRACK);
        repeat (DEPTH) text_bytes.push_back(CH_RBRACK);
        send_text();

        // hold the sink off while single-byte error texts keep coming
        hold_reqs <= hold_reqs + 1;
        repeat (30) send_str(")");
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (n_awaited != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d texts in %0d bytes, %0d results compared.",
                 n_texts, n_bytes, n_checked);
        $display("Included a full stack, an overflow and a long-stalled sink.");
        if (n_faults == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/dmc_stack.sv
rtl/delimiter_match_checker_unit.sv
tb/bracket_status_monitor.sv
tb/delimiter_match_checker_unit_test.sv
